>>> design/b64d_pkg.sv
// Types, codes and the character decode function for the Base64 stream decoder.
// No dependencies; every other design file except b64d_stream_if imports this package.
`default_nettype none

package b64d_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_CHAR = 2'd1,
		STATUS_LENGTH   = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_text;
	} text_word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] status;
		logic       last_of_run;
	} data_word_t;

	// one decoded quartet (or a length error) waiting for the byte emitter
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  count;
		status_t     status;
	} job_t;

	typedef struct packed {
		logic       invalid;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t    r;
		logic [7:0] d;
		r = '{invalid: 1'b1, value: 6'd0};
		d = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			r = '{invalid: 1'b0, value: d[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'd71;
			r = '{invalid: 1'b0, value: d[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c + 8'd4;
			r = '{invalid: 1'b0, value: d[5:0]};
		end else if (c == 8'h2B) begin
			r = '{invalid: 1'b0, value: 6'd62};
		end else if (c == 8'h2F) begin
			r = '{invalid: 1'b0, value: 6'd63};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/b64d_stream_if.sv
// Valid/ready stream channel carrying one word of a chosen payload type.
// Used for the character input and the byte output of the decoder.
`default_nettype none

interface b64d_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/b64d_queue.sv
// Short job queue between the quartet assembler and the byte emitter.
// Depends on b64d_pkg for the job type.
`default_nettype none

module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64d_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output b64d_pkg::job_t      head
);
	import b64d_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/b64d_front.sv
// Quartet assembler: accepts characters, decodes them, collects four sextets
// and pushes a job per completed quartet or length error. Depends on b64d_pkg.
`default_nettype none

module b64d_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_fire,
	input  wire b64d_pkg::text_word_t in_word,
	output logic                push,
	output b64d_pkg::job_t      push_job
);
	import b64d_pkg::*;

	logic [17:0] acc_q;
	logic [1:0]  pos_q;
	logic        third_pad_q;
	logic        bad_q;

	sextet_t     sx;
	logic        is_pad;
	logic        bad;
	logic [5:0]  v;
	logic        eot;
	logic        drop_last;
	logic        drop_third;

	always_comb begin
		sx         = sextet_of(in_word.symbol);
		is_pad     = (in_word.symbol == PAD_CHAR);
		bad        = !is_pad && sx.invalid;
		v          = (is_pad || sx.invalid) ? 6'd0 : sx.value;
		eot        = in_word.end_of_text;
		drop_last  = eot && is_pad;
		drop_third = eot && third_pad_q;
	end

	always_comb begin
		push     = 1'b0;
		push_job = '{bits: 24'd0, count: 2'd1, status: STATUS_LENGTH};
		if (in_fire) begin
			if (pos_q == 2'd3) begin
				push          = 1'b1;
				push_job.bits = {acc_q, v};
				push_job.count = 2'd3 - {1'b0, drop_last} - {1'b0, drop_third};
				push_job.status = (bad_q || bad) ? STATUS_BAD_CHAR : STATUS_OK;
			end else if (eot) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pos_q       <= '0;
			third_pad_q <= 1'b0;
			bad_q       <= 1'b0;
		end else if (in_fire) begin
			if (pos_q == 2'd3 || eot) begin
				acc_q       <= '0;
				pos_q       <= '0;
				third_pad_q <= 1'b0;
				bad_q       <= 1'b0;
			end else begin
				acc_q <= {acc_q[11:0], v};
				pos_q <= pos_q + 2'd1;
				if (pos_q == 2'd0) begin
					bad_q       <= bad;
					third_pad_q <= 1'b0;
				end else begin
					bad_q <= bad_q || bad;
					if (pos_q == 2'd2) begin
						third_pad_q <= is_pad;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> design/b64d_back.sv
// Byte emitter: takes jobs from the queue and sends their bytes, most
// significant first, through a registered output stage. Depends on b64d_pkg.
`default_nettype none

module b64d_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           empty,
	input  wire b64d_pkg::job_t head,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output b64d_pkg::data_word_t out_word
);
	import b64d_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	data_word_t word_q;

	logic       load;
	logic       last;
	logic [7:0] sel_byte;

	always_comb begin
		load = !empty && (!valid_q || out_ready);
		last = ((idx_q + 2'd1) == head.count);
		pop  = load && last;
		case (idx_q)
			2'd0:    sel_byte = head.bits[23:16];
			2'd1:    sel_byte = head.bits[15:8];
			default: sel_byte = head.bits[7:0];
		endcase
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q.data_byte   <= sel_byte;
			word_q.status      <= head.status;
			word_q.last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/base64_stream_decoder.sv
// Base64 stream decoder top level: front assembler, job queue and byte emitter.
// Depends on b64d_pkg, b64d_stream_if, b64d_front, b64d_queue and b64d_back.
//
// Usage:
//   text: one character word per handshake, symbol plus end_of_text.
//   data: decoded byte words with status and last_of_run.
//   Each fourth character of a quartet yields three bytes (fewer for a padded
//   final quartet); end of text inside a quartet yields one length-error word.
//   Other characters yield nothing.
// Timing:
//   A quartet's job passes through the job queue and the registered output
//   stage; its bytes follow one per cycle while data.ready is high.
//   One character is accepted per cycle while the job queue is not full; the
//   emitter sends one byte per cycle, so four characters per three bytes
//   let it keep pace with the input without backing up.
// Reset and stalls:
//   arst_n clears the quartet state, the queue and the output stage.
//   A stalled receiver holds the output word; the queue of QUEUE_DEPTH jobs
//   fills and text.ready drops only when it is full.
`default_nettype none

module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input wire logic      clk,
	input wire logic      arst_n,
	b64d_stream_if.sink   text,
	b64d_stream_if.source data
);
	import b64d_pkg::*;

	logic       full;
	logic       empty;
	logic       push;
	logic       pop;
	job_t       push_job;
	job_t       head;
	logic       in_fire;
	data_word_t out_word;

	assign text.ready   = !full;
	assign in_fire      = text.valid && !full;
	assign data.payload = out_word;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_word  (text.payload),
		.push     (push),
		.push_job (push_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (data.valid),
		.out_ready (data.ready),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

>>> design/b64d_checker.sv
// Port-level checks for the Base64 stream decoder output, bound to the top.
// Depends on b64d_pkg for the status codes.
`default_nettype none

module b64d_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic [1:0] out_status,
	input wire logic       out_last
);
	import b64d_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(out_status) && $stable(out_last))
		else $error("output word changed while stalled");

	a_length_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == STATUS_LENGTH |-> out_byte == 8'd0 && out_last)
		else $error("length error word not zero or not last");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status == STATUS_OK || out_status == STATUS_BAD_CHAR
			|| out_status == STATUS_LENGTH)
		else $error("undefined status code");

	a_run_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !out_valid
			|| (out_status == $past(out_status) && out_status != STATUS_LENGTH))
		else $error("status changed inside a quartet");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (data.valid),
	.out_ready  (data.ready),
	.out_byte   (data.payload.data_byte),
	.out_status (data.payload.status),
	.out_last   (data.payload.last_of_run)
);

`default_nettype wire
